>>> rtl/core/hhbt_pkg.sv
`timescale 1ns / 1ps

package hhbt_pkg;

  // header count limit and line characters
  localparam logic [7:0] HEADER_LIMIT = 8'd128;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_SP        = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_COLON     = 8'h3A;

  // result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // phases
  localparam logic [1:0] PH_REQ  = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  // field tags
  localparam logic [3:0] TAG_BLANK   = 4'd0;
  localparam logic [3:0] TAG_METHOD  = 4'd1;
  localparam logic [3:0] TAG_EXTRA   = 4'd4;
  localparam logic [3:0] TAG_HNAME   = 4'd5;
  localparam logic [3:0] TAG_HVALUE  = 4'd6;
  localparam logic [3:0] TAG_CRLF    = 4'd7;
  localparam logic [3:0] TAG_BODY    = 4'd8;

  // line events
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_REQ_DONE  = 3'd1;
  localparam logic [2:0] EV_HDR_TAKEN = 3'd2;
  localparam logic [2:0] EV_HDR_DROP  = 3'd3;
  localparam logic [2:0] EV_HDR_END   = 3'd4;
  localparam logic [2:0] EV_REQ_BAD   = 3'd5;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] field_tag;
    logic [7:0] header_index;
    logic [2:0] line_event;
    logic       last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       cr_held;
    logic       line_empty;
    logic [1:0] token_number;
    logic       inside_token;
    logic       colon_seen;
    logic       value_started;
    logic [7:0] headers_taken;
  } st_t;

  localparam st_t ST_RESET = '{
    phase: PH_REQ, cr_held: 1'b0, line_empty: 1'b1, token_number: 2'd0,
    inside_token: 1'b0, colon_seen: 1'b0, value_started: 1'b0,
    headers_taken: 8'd0
  };

endpackage

>>> rtl/core/hhbt_if.sv
`timescale 1ns / 1ps

// input byte channel
interface hhbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// tagged result channel
interface hhbt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [3:0] field_tag;
  logic [7:0] header_index;
  logic [2:0] line_event;
  logic       last_of_run;

  modport source (output valid, output out_byte, output field_tag,
                  output header_index, output line_event, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_byte, input field_tag,
                  input header_index, input line_event, input last_of_run,
                  output ready);
endinterface

>>> rtl/core/hhbt_classify.sv
`timescale 1ns / 1ps

module hhbt_classify
  import hhbt_pkg::*;
(
  input  st_t        st,
  input  logic [7:0] data_byte,
  output st_t        st_nxt,
  output res_t       res0,
  output res_t       res1,
  output logic [1:0] res_n
);

  typedef struct packed {
    st_t        st;
    logic [3:0] tag;
  } cls_t;

  typedef struct packed {
    st_t        st;
    logic [2:0] ev;
  } eol_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

  // tag one ordinary byte and advance the token/header flags
  function automatic cls_t classify(input st_t s, input logic [7:0] c);
    cls_t r;
    r.st = s;
    r.st.line_empty = 1'b0;
    r.tag = TAG_BLANK;
    if (s.phase == PH_REQ) begin
      if (is_blank(c)) begin
        if (s.inside_token) begin
          r.st.inside_token = 1'b0;
          if (s.token_number != 2'd3) r.st.token_number = s.token_number + 2'd1;
        end
      end else begin
        r.st.inside_token = 1'b1;
        r.tag = (s.token_number != 2'd3) ? ({2'b00, s.token_number} + TAG_METHOD)
                                         : TAG_EXTRA;
      end
    end else if (!s.colon_seen) begin
      if (c == CH_COLON) begin
        r.st.colon_seen = 1'b1;
      end else begin
        r.tag = TAG_HNAME;
      end
    end else if (!s.value_started && is_blank(c)) begin
      r.tag = TAG_BLANK;
    end else begin
      r.st.value_started = 1'b1;
      r.tag = TAG_HVALUE;
    end
    return r;
  endfunction

  // close a line at cr lf and pick its event
  function automatic eol_t end_line(input st_t s);
    eol_t r;
    logic tok3;
    tok3 = (s.token_number == 2'd3) || (s.token_number == 2'd2 && s.inside_token);
    r.st = s;
    if (s.line_empty) begin
      r.ev = EV_HDR_END;
      r.st.phase = PH_BODY;
    end else if (s.phase == PH_REQ) begin
      r.ev = tok3 ? EV_REQ_DONE : EV_REQ_BAD;
      r.st.phase = PH_HDR;
    end else if (s.colon_seen && (s.headers_taken < HEADER_LIMIT)) begin
      r.st.headers_taken = s.headers_taken + 8'd1;
      r.ev = EV_HDR_TAKEN;
    end else begin
      r.ev = EV_HDR_DROP;
    end
    r.st.line_empty    = 1'b1;
    r.st.token_number  = 2'd0;
    r.st.inside_token  = 1'b0;
    r.st.colon_seen    = 1'b0;
    r.st.value_started = 1'b0;
    return r;
  endfunction

  // per-byte decision, up to two results
  always_comb begin
    cls_t       c0;
    cls_t       c1;
    eol_t       e;
    logic [7:0] idx;
    st_t        s;
    c0 = '0;
    c1 = '0;
    e  = '0;
    s  = st;
    idx = (st.phase == PH_REQ) ? 8'd0 : st.headers_taken;
    st_nxt = st;
    res0 = '0;
    res1 = '0;
    res_n = 2'd0;
    if (st.phase[1]) begin
      // body and unused phase code
      res0 = '{data_byte, TAG_BODY, st.headers_taken, EV_NONE, 1'b0};
      res_n = 2'd1;
    end else if (st.cr_held) begin
      s.cr_held = 1'b0;
      if (data_byte == CH_LF) begin
        e = end_line(s);
        st_nxt = e.st;
        res0 = '{CH_CR, TAG_CRLF, idx, EV_NONE, 1'b0};
        res1 = '{CH_LF, TAG_CRLF, idx, e.ev, 1'b0};
        res_n = 2'd2;
      end else begin
        // held cr turns into an ordinary byte
        c0 = classify(s, CH_CR);
        res0 = '{CH_CR, c0.tag, idx, EV_NONE, 1'b0};
        if (data_byte == CH_CR) begin
          st_nxt = c0.st;
          st_nxt.cr_held = 1'b1;
          res_n = 2'd1;
        end else begin
          c1 = classify(c0.st, data_byte);
          st_nxt = c1.st;
          res1 = '{data_byte, c1.tag, idx, EV_NONE, 1'b0};
          res_n = 2'd2;
        end
      end
    end else if (data_byte == CH_CR) begin
      st_nxt.cr_held = 1'b1;
    end else begin
      c0 = classify(st, data_byte);
      st_nxt = c0.st;
      res0 = '{data_byte, c0.tag, idx, EV_NONE, 1'b0};
      res_n = 2'd1;
    end
    res0.last_of_run = (res_n == 2'd1);
    res1.last_of_run = 1'b1;
  end

endmodule

>>> rtl/core/http_header_byte_tokenizer_core.sv
`timescale 1ns / 1ps

// http request byte tokenizer
// in_ch: one raw byte per word (data_byte), valid/ready handshake.
// out_ch: one tagged byte per word (out_byte, field_tag, header_index,
//   line_event, last_of_run); a byte yields zero, one or two words, and
//   last_of_run marks the final word of each input byte.
// a cr in the request line or headers is held and shows up together with
//   the following byte, so it yields no word on its own cycle.
// an accepted byte's words enter the result queue at the edge that accepts it.
// throughput: one byte per cycle while bytes yield one word each and the
//   receiver keeps up; a byte that yields two words (cr lf, or a held cr
//   released) leaves through the single-word output port one word at a time.
// results sit in a four-word queue; in_ch.ready is high while the queue
//   has room for two words, so a stalled receiver backs up to the input
//   as soon as three or four words are queued and nothing is lost.
// reset (rst_n low, synchronous): queue empties, parser returns to the
//   start of the request line with a header count of zero.
module http_header_byte_tokenizer_core
  import hhbt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  hhbt_in_if.sink          in_ch,
  hhbt_out_if.source       out_ch
);

  st_t              st_r;
  st_t              st_nxt;
  res_t             res0;
  res_t             res1;
  logic [1:0]       res_n;
  res_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             in_fire;
  logic             out_fire;
  res_t             head;

  hhbt_classify u_classify (
    .st        (st_r),
    .data_byte (in_ch.data_byte),
    .st_nxt    (st_nxt),
    .res0      (res0),
    .res1      (res1),
    .res_n     (res_n)
  );

  assign in_ch.ready = (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (in_fire && res_n != 2'd0) begin
      mem_r[wptr_r] <= res0;
    end
    if (in_fire && res_n == 2'd2) begin
      mem_r[wptr_r + PTR_W'(1)] <= res1;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (in_fire) begin
        wptr_r <= wptr_r + PTR_W'(res_n);
      end
      if (out_fire) begin
        rptr_r <= rptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + (in_fire ? CNT_W'(res_n) : CNT_W'(0))
                     - (out_fire ? CNT_W'(1) : CNT_W'(0));
    end
  end

  // output word from queue head
  assign head                = mem_r[rptr_r];
  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.out_byte     = head.out_byte;
  assign out_ch.field_tag    = head.field_tag;
  assign out_ch.header_index = head.header_index;
  assign out_ch.line_event   = head.line_event;
  assign out_ch.last_of_run  = head.last_of_run;

  // queue never overfills
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  // a pair is written at once, so its second word is already queued
  a_pair_whole: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last_of_run |-> cnt_r >= CNT_W'(2))
    else $error("first word of a pair without its partner");

  // a byte that yields words shows one on the next cycle
  a_word_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res_n != 2'd0 |=> out_ch.valid)
    else $error("accepted byte produced no queued word");

  // line events only ride on line-end words
  a_event_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.line_event != EV_NONE |-> out_ch.field_tag == TAG_CRLF)
    else $error("line event on a word that is not a line end");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import hhbt_pkg::*;

  localparam int unsigned N_ITEMS     = 750;
  localparam int unsigned MIN_BODY    = 16;
  localparam int unsigned EXTRA_DROPS = 3;
  localparam int unsigned HOLD_AT     = 100;
  localparam int unsigned HOLD_LEN    = 160;
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam int unsigned CLK_LIMIT   = 200000;

  // expected word store and byte tagging predictor
  class tag_scoreboard;
    st_t         st;
    res_t        due_q[$];
    int unsigned n_bad;

    function new();
      st    = ST_RESET;
      n_bad = 0;
    endfunction

    function bit blank_char(logic [7:0] c);
      return (c == CH_SP) || (c == CH_TAB);
    endfunction

    // tag an ordinary byte and advance token / header state
    function logic [3:0] tag_byte(logic [7:0] c);
      st.line_empty = 1'b0;
      if (st.phase == PH_REQ) begin
        if (blank_char(c)) begin
          if (st.inside_token) begin
            st.inside_token = 1'b0;
            if (!(&st.token_number)) st.token_number++;
          end
          return TAG_BLANK;
        end
        st.inside_token = 1'b1;
        return (&st.token_number) ? TAG_EXTRA : TAG_METHOD + 4'(st.token_number);
      end
      if (!st.colon_seen) begin
        if (c == CH_COLON) begin
          st.colon_seen = 1'b1;
          return TAG_BLANK;
        end
        return TAG_HNAME;
      end
      if (!st.value_started) begin
        if (blank_char(c)) return TAG_BLANK;
        st.value_started = 1'b1;
      end
      return TAG_HVALUE;
    endfunction

    // finish a line at cr lf and give its event
    function logic [2:0] close_line();
      logic [2:0] ev;
      logic [2:0] tokens;
      tokens = 3'(st.token_number);
      if (st.inside_token && !(&st.token_number)) tokens++;
      if (st.line_empty) begin
        ev       = EV_HDR_END;
        st.phase = PH_BODY;
      end else if (st.phase == PH_REQ) begin
        ev       = (tokens >= 3) ? EV_REQ_DONE : EV_REQ_BAD;
        st.phase = PH_HDR;
      end else if (st.colon_seen && st.headers_taken < HEADER_LIMIT) begin
        st.headers_taken++;
        ev = EV_HDR_TAKEN;
      end else begin
        ev = EV_HDR_DROP;
      end
      st.line_empty    = 1'b1;
      st.token_number  = '0;
      st.inside_token  = 1'b0;
      st.colon_seen    = 1'b0;
      st.value_started = 1'b0;
      return ev;
    endfunction

    function void push_word(logic [7:0] c, logic [3:0] tag, logic [7:0] idx,
                            logic [2:0] ev);
      res_t w;
      w.out_byte     = c;
      w.field_tag    = tag;
      w.header_index = idx;
      w.line_event   = ev;
      w.last_of_run  = 1'b0;
      due_q.push_back(w);
    endfunction

    // accepted input byte: queue the words it yields
    function void note_input(logic [7:0] c);
      int unsigned n0;
      logic [7:0]  idx;
      logic [2:0]  ev;
      n0  = due_q.size();
      idx = (st.phase == PH_REQ) ? 8'd0 : st.headers_taken;
      if (st.phase >= PH_BODY) begin
        push_word(c, TAG_BODY, st.headers_taken, EV_NONE);
      end else if (st.cr_held) begin
        st.cr_held = 1'b0;
        if (c == CH_LF) begin
          push_word(CH_CR, TAG_CRLF, idx, EV_NONE);
          ev = close_line();
          push_word(CH_LF, TAG_CRLF, idx, ev);
        end else begin
          // held cr was not a line end, it is an ordinary byte
          push_word(CH_CR, tag_byte(CH_CR), idx, EV_NONE);
          if (c == CH_CR) st.cr_held = 1'b1;
          else push_word(c, tag_byte(c), idx, EV_NONE);
        end
      end else if (c == CH_CR) begin
        st.cr_held = 1'b1;
      end else begin
        push_word(c, tag_byte(c), idx, EV_NONE);
      end
      if (due_q.size() > n0) due_q[due_q.size() - 1].last_of_run = 1'b1;
    endfunction

    task report_error(string msg);
      n_bad++;
      if (n_bad <= 30) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // accepted output word against the oldest expectation
    task check_result(res_t got);
      res_t  want;
      string bad;
      if (due_q.size() == 0) begin
        report_error($sformatf("unexpected word %h tag %0d", got.out_byte,
                               got.field_tag));
        return;
      end
      want = due_q.pop_front();
      bad  = "";
      if (got.out_byte !== want.out_byte) bad = {bad, " out_byte"};
      if (got.field_tag !== want.field_tag) bad = {bad, " field_tag"};
      if (got.header_index !== want.header_index) bad = {bad, " header_index"};
      if (got.line_event !== want.line_event) bad = {bad, " line_event"};
      if (got.last_of_run !== want.last_of_run) bad = {bad, " last_of_run"};
      if (bad != "")
        report_error($sformatf("got %h/%0d/%0d/%0d/%0d want %h/%0d/%0d/%0d/%0d:%s",
                               got.out_byte, got.field_tag, got.header_index,
                               got.line_event, got.last_of_run, want.out_byte,
                               want.field_tag, want.header_index, want.line_event,
                               want.last_of_run, bad));
    endtask
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  hhbt_in_if  in_ch();
  hhbt_out_if out_ch();

  http_header_byte_tokenizer_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tag_scoreboard sb = new();

  int unsigned clk_count  = 0;
  int unsigned burst_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned words_seen = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    clk_count <= clk_count + 1;
    if (clk_count == CLK_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: check accepted words, stall on its own pattern, one long hold
  always @(posedge clk) begin
    res_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.out_byte     = out_ch.out_byte;
        got.field_tag    = out_ch.field_tag;
        got.header_index = out_ch.header_index;
        got.line_event   = out_ch.line_event;
        got.last_of_run  = out_ch.last_of_run;
        sb.check_result(got);
        words_seen++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && words_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        out_ch.ready <= 1'b0;
      end else begin
        case (clk_count[8:7])
          2'd0: out_ch.ready <= 1'b1;
          2'd1: out_ch.ready <= !(clk_count[2] && clk_count[0]);
          2'd2: out_ch.ready <= ($urandom_range(0, 2) != 0);
          default: out_ch.ready <= (clk_count[5:4] != 2'b11);
        endcase
      end
    end
  end

  // offer one byte, in bursts with random gaps, and wait for the handshake
  task send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(b);
    bytes_sent++;
  endtask

  task send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // random byte that cannot form a line end by accident
  function logic [7:0] pick_byte(bit no_colon, bit no_lf);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_CR || (no_colon && c == CH_COLON) || (no_lf && c == CH_LF));
    return c;
  endfunction

  // one header line: mostly well formed, some without colon, some noise
  task send_header();
    int unsigned kind;
    kind = $urandom_range(0, 15);
    if (kind == 0) begin
      // noise with a cr that does not end the line
      send_byte(pick_byte(1'b0, 1'b0));
      send_byte(CH_CR);
      send_byte(pick_byte(1'b0, 1'b1));
    end else if (kind == 1) begin
      repeat ($urandom_range(1, 3)) send_byte(pick_byte(1'b1, 1'b0));
    end else begin
      send_byte(pick_byte(1'b1, 1'b0));
      send_byte(CH_COLON);
      if ($urandom_range(0, 1) != 0) send_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
      repeat ($urandom_range(0, 1)) send_byte(pick_byte(1'b0, 1'b0));
    end
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  initial begin
    int unsigned variant;
    int unsigned drops_after;
    int unsigned body_sent;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // request line: empty, short, or full with extra tokens and stray crs
    variant = $urandom_range(0, 7);
    if (variant == 0) send_text("\r\n");
    else if (variant == 1) send_text("\tGET\n  /x\r\n");
    else send_text(" M\t/p\377 V\n E x\rq\r\r\n");

    if (sb.st.phase == PH_HDR) begin
      // directed headers: odd name, blanks and a second colon, no colon, empty value
      send_byte(8'h00);
      send_text("N\n:\t v:\r\n");
      send_text("x\r\n");
      send_text(":\r\n");
      // random headers up to the count limit and a few past it
      drops_after = 0;
      while (sb.st.headers_taken < HEADER_LIMIT || drops_after < EXTRA_DROPS) begin
        if (sb.st.headers_taken == HEADER_LIMIT) drops_after++;
        send_header();
      end
      send_text("\r\n");
    end

    // body bytes of any value
    body_sent = 0;
    while (bytes_sent < N_ITEMS || body_sent < MIN_BODY) begin
      send_byte(8'($urandom_range(0, 255)));
      body_sent++;
    end
    in_ch.valid <= 1'b0;

    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.n_bad == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
